// ----- rtl/core/bilinear_texture_sampler_defines.svh -----
// assertion macros shared by the texture sampler rtl
`ifndef BILINEAR_TEXTURE_SAMPLER_DEFINES_SVH
`define BILINEAR_TEXTURE_SAMPLER_DEFINES_SVH

// concurrent assertion on a given clock and active-low reset
`define BTS_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define BTS_ASSERT(lbl, prop, msg) `BTS_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/core/bts_pkg.sv -----
// types, constants and helpers of the bilinear texture sampler
`default_nettype none
package bts_pkg;
  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned TEXEL_W = 3 * CH_W;
  localparam int unsigned CRD_W   = 18;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned UC_W    = FRAC_W + 1;
  localparam int unsigned WSZ_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HSZ_W   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned X_W     = $clog2(MAX_WIDTH);
  localparam int unsigned Y_W     = $clog2(MAX_HEIGHT);
  localparam int unsigned TX_W    = FRAC_W + X_W;
  localparam int unsigned TY_W    = FRAC_W + Y_W;
  localparam int unsigned WGT_W   = 2 * FRAC_W + 1;
  localparam int unsigned PRD_W   = WGT_W + CH_W;
  localparam int unsigned SUM_W   = PRD_W + 2;
  localparam int unsigned NTAP    = 4;
  localparam logic [UC_W-1:0] ONE_Q16 = UC_W'(1) << FRAC_W;
  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(256);

  typedef enum logic {
    CFG_TEX_WIDTH  = 1'b0,
    CFG_TEX_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_e;

  typedef struct packed {
    logic valid;
    logic smp;
  } ctl_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  typedef logic [IDX_W-1:0] addr_t;
  typedef logic [WGT_W-1:0] wgt_t;

  function automatic logic [UC_W-1:0] clamp_coord(input logic signed [CRD_W-1:0] c);
    logic [UC_W-1:0] m;
    m = c[UC_W-1:0];
    if (c[CRD_W-1]) begin
      return '0;
    end else if (m > ONE_Q16) begin
      return ONE_Q16;
    end
    return m;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/bts_if.sv -----
// request and result channel interfaces of the texture sampler
`default_nettype none
interface bts_req_if;
  import bts_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [IDX_W-1:0]        texel_index;
  logic [CH_W-1:0]         texel_red;
  logic [CH_W-1:0]         texel_green;
  logic [CH_W-1:0]         texel_blue;
  logic signed [CRD_W-1:0] coord_u;
  logic signed [CRD_W-1:0] coord_v;
  modport source (output valid, func, texel_index, texel_red, texel_green, texel_blue,
                  coord_u, coord_v, input ready);
  modport sink (input valid, func, texel_index, texel_red, texel_green, texel_blue,
                coord_u, coord_v, output ready);
endinterface

interface bts_rsp_if;
  import bts_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/bts_coord.sv -----
// coordinate clamp and scale, tap addresses and bilinear weights
`default_nettype none
module bts_coord (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic                             func_i,
  input  logic [bts_pkg::IDX_W-1:0]        index_i,
  input  bts_pkg::rgb_t                    texel_i,
  input  logic signed [bts_pkg::CRD_W-1:0] u_i,
  input  logic signed [bts_pkg::CRD_W-1:0] v_i,
  input  logic [bts_pkg::WSZ_W-1:0]        width_i,
  input  logic [bts_pkg::HSZ_W-1:0]        height_i,
  output bts_pkg::ctl_t                    ctl_o,
  output bts_pkg::addr_t                   addr_o [bts_pkg::NTAP],
  output bts_pkg::wgt_t                    wgt_o [bts_pkg::NTAP],
  output logic [bts_pkg::IDX_W-1:0]        index_o,
  output bts_pkg::rgb_t                    texel_o
);
  import bts_pkg::*;

  ctl_t              ctl1_q, ctl2_q;
  logic [TX_W-1:0]   tx1_q;
  logic [TY_W-1:0]   ty1_q;
  logic [WSZ_W-1:0]  w1_q;
  logic [IDX_W-1:0]  idx1_q, idx2_q;
  rgb_t              tex1_q, tex2_q;
  addr_t             addr2_q [NTAP];
  wgt_t              wgt2_q [NTAP];

  logic [UC_W-1:0]   uc, vc;
  logic [X_W-1:0]    wm1, x0;
  logic [Y_W-1:0]    hm1, y0;
  logic [FRAC_W-1:0] fx, fy;
  logic [UC_W-1:0]   ofx, ofy;
  addr_t             xa0, xa1, yw0, yw1;

  always_comb begin
    uc  = clamp_coord(u_i);
    vc  = clamp_coord(v_i);
    wm1 = X_W'(width_i - WSZ_W'(1));
    hm1 = Y_W'(height_i - HSZ_W'(1));
  end

  always_comb begin
    x0  = tx1_q[TX_W-1:FRAC_W];
    y0  = ty1_q[TY_W-1:FRAC_W];
    fx  = tx1_q[FRAC_W-1:0];
    fy  = ty1_q[FRAC_W-1:0];
    ofx = ONE_Q16 - UC_W'(fx);
    ofy = ONE_Q16 - UC_W'(fy);
    xa0 = IDX_W'(x0);
    xa1 = xa0 + IDX_W'(fx != '0);
    yw0 = IDX_W'(32'(y0) * 32'(w1_q));
    yw1 = (fy != '0) ? yw0 + IDX_W'(w1_q) : yw0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl1_q <= '{valid: valid_i, smp: func_i == FUNC_SAMPLE};
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tx1_q      <= TX_W'(32'(uc) * 32'(wm1));
      ty1_q      <= TY_W'(32'(vc) * 32'(hm1));
      w1_q       <= width_i;
      idx1_q     <= index_i;
      tex1_q     <= texel_i;
      idx2_q     <= idx1_q;
      tex2_q     <= tex1_q;
      addr2_q[0] <= xa0 + yw0;
      addr2_q[1] <= xa1 + yw0;
      addr2_q[2] <= xa0 + yw1;
      addr2_q[3] <= xa1 + yw1;
      wgt2_q[0]  <= WGT_W'(34'(ofx) * 34'(ofy));
      wgt2_q[1]  <= WGT_W'(34'(fx) * 34'(ofy));
      wgt2_q[2]  <= WGT_W'(34'(ofx) * 34'(fy));
      wgt2_q[3]  <= WGT_W'(34'(fx) * 34'(fy));
    end
  end

  assign ctl_o   = ctl2_q;
  assign addr_o  = addr2_q;
  assign wgt_o   = wgt2_q;
  assign index_o = idx2_q;
  assign texel_o = tex2_q;
endmodule
`default_nettype wire

// ----- rtl/core/bts_fetch.sv -----
// texture store, one copy per tap, written by loads and read by samples
`default_nettype none
module bts_fetch (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  bts_pkg::ctl_t             ctl_i,
  input  bts_pkg::addr_t            addr_i [bts_pkg::NTAP],
  input  bts_pkg::wgt_t             wgt_i [bts_pkg::NTAP],
  input  logic [bts_pkg::IDX_W-1:0] index_i,
  input  bts_pkg::rgb_t             texel_i,
  output bts_pkg::ctl_t             ctl_o,
  output bts_pkg::rgb_t             tap_o [bts_pkg::NTAP],
  output bts_pkg::wgt_t             wgt_o [bts_pkg::NTAP]
);
  import bts_pkg::*;

  localparam int unsigned Depth = 1 << IDX_W;

  ctl_t  ctl3_q;
  rgb_t  tap3_q [NTAP];
  wgt_t  wgt3_q [NTAP];
  logic  wr_en, rd_en;

  assign wr_en = en_i && ctl_i.valid && !ctl_i.smp;
  assign rd_en = en_i && ctl_i.valid && ctl_i.smp;

  for (genvar k = 0; k < NTAP; k++) begin : g_copy
    rgb_t store_mem [Depth];
    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        store_mem[index_i] <= texel_i;
      end
      if (rd_en) begin
        tap3_q[k] <= store_mem[addr_i[k]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
    end else if (en_i) begin
      ctl3_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wgt3_q <= wgt_i;
    end
  end

  assign ctl_o = ctl3_q;
  assign tap_o = tap3_q;
  assign wgt_o = wgt3_q;
endmodule
`default_nettype wire

// ----- rtl/core/bts_blend.sv -----
// weighted tap products, sum and rounding per channel
`default_nettype none
module bts_blend (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  bts_pkg::ctl_t ctl_i,
  input  bts_pkg::rgb_t tap_i [bts_pkg::NTAP],
  input  bts_pkg::wgt_t wgt_i [bts_pkg::NTAP],
  output bts_pkg::ctl_t ctl_o,
  output bts_pkg::rgb_t rgb_o
);
  import bts_pkg::*;

  localparam logic [SUM_W-1:0] Half = SUM_W'(1) << (2 * FRAC_W - 1);

  ctl_t             ctl4_q;
  logic [PRD_W-1:0] prd_q [3][NTAP];
  logic [CH_W-1:0]  chn [3][NTAP];
  logic [SUM_W-1:0] sum [3];

  always_comb begin
    for (int k = 0; k < NTAP; k++) begin
      chn[0][k] = tap_i[k].r;
      chn[1][k] = tap_i[k].g;
      chn[2][k] = tap_i[k].b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < NTAP; k++) begin
          prd_q[c][k] <= PRD_W'(PRD_W'(chn[c][k]) * PRD_W'(wgt_i[k]));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q <= '0;
    end else if (en_i) begin
      ctl4_q <= ctl_i;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = SUM_W'(prd_q[c][0]) + SUM_W'(prd_q[c][1]) + SUM_W'(prd_q[c][2])
             + SUM_W'(prd_q[c][3]) + Half;
    end
    rgb_o.r = sum[0][2*FRAC_W +: CH_W];
    rgb_o.g = sum[1][2*FRAC_W +: CH_W];
    rgb_o.b = sum[2][2*FRAC_W +: CH_W];
  end

  assign ctl_o = ctl4_q;
endmodule
`default_nettype wire

// ----- rtl/core/bilinear_texture_sampler.sv -----
// top level of the bilinear texture sampler
//
//   channel   dir  handshake     payload
//   req_if    in   valid/ready   func, texel_index, texel rgb, coord_u, coord_v
//   rsp_if    out  valid/ready   out_red, out_green, out_blue
//   cfg       in   cfg_we_i      cfg_idx_i, cfg_data_i
//
// one request per cycle while the result is not stalled; a sample result passes
// through the five register stages: scale, address/weight, memory read,
// product, output
// a load writes all four store copies at the memory read stage; no result
// a stalled result holds the whole pipeline; reset clears valid bits and sizes only
`default_nettype none
`include "bilinear_texture_sampler_defines.svh"
module bilinear_texture_sampler (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [bts_pkg::CFG_W-1:0] cfg_data_i,
  bts_req_if.sink                   req_if,
  bts_rsp_if.source                 rsp_if
);
  import bts_pkg::*;

  logic [CFG_W-1:0] width_q, height_q;
  logic [WSZ_W-1:0] w_eff;
  logic [HSZ_W-1:0] h_eff;
  logic             en;
  ctl_t             ctl2, ctl3, ctl4;
  addr_t            addr2 [NTAP];
  wgt_t             wgt2 [NTAP], wgt3 [NTAP];
  logic [IDX_W-1:0] idx2;
  rgb_t             tex_in, tex2, rgb4;
  rgb_t             tap3 [NTAP];
  logic             out_valid_q;
  rgb_t             out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_RESET;
      height_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TEX_WIDTH:  width_q  <= cfg_data_i;
        CFG_TEX_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = WSZ_W'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WSZ_W'(MAX_WIDTH);
    end else begin
      w_eff = WSZ_W'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HSZ_W'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HSZ_W'(MAX_HEIGHT);
    end else begin
      h_eff = HSZ_W'(height_q);
    end
  end

  assign en           = !out_valid_q || rsp_if.ready;
  assign req_if.ready = en;
  assign tex_in       = '{r: req_if.texel_red, g: req_if.texel_green, b: req_if.texel_blue};

  bts_coord u_coord (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (req_if.valid),
    .func_i   (req_if.func),
    .index_i  (req_if.texel_index),
    .texel_i  (tex_in),
    .u_i      (req_if.coord_u),
    .v_i      (req_if.coord_v),
    .width_i  (w_eff),
    .height_i (h_eff),
    .ctl_o    (ctl2),
    .addr_o   (addr2),
    .wgt_o    (wgt2),
    .index_o  (idx2),
    .texel_o  (tex2)
  );

  bts_fetch u_fetch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (ctl2),
    .addr_i  (addr2),
    .wgt_i   (wgt2),
    .index_i (idx2),
    .texel_i (tex2),
    .ctl_o   (ctl3),
    .tap_o   (tap3),
    .wgt_o   (wgt3)
  );

  bts_blend u_blend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (ctl3),
    .tap_i  (tap3),
    .wgt_i  (wgt3),
    .ctl_o  (ctl4),
    .rgb_o  (rgb4)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctl4.valid && ctl4.smp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= rgb4;
    end
  end

  assign rsp_if.valid     = out_valid_q;
  assign rsp_if.out_red   = out_q.r;
  assign rsp_if.out_green = out_q.g;
  assign rsp_if.out_blue  = out_q.b;

  `BTS_ASSERT(a_stall_hold, !en |=> $stable(ctl2) && $stable(ctl3) && $stable(ctl4), "pipeline moved in stall")
  `BTS_ASSERT(a_out_from_sample, $rose(out_valid_q) |-> $past(ctl4.valid && ctl4.smp), "result without sample")
  `BTS_ASSERT(a_fetch_follows, (en && ctl2.valid && ctl2.smp) |=> (ctl3.valid && ctl3.smp), "sample lost at fetch")
endmodule
`default_nettype wire
